@@ rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants and types of the prefix code tree decoder: table geometry,
// command codes and the node memory request bundle.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int MAX_CODE_LEN = 13;
	localparam int TABLE_DEPTH  = 16384;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 13;
	localparam int LEN_W  = 4;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);

	localparam int NODE_W = ((MAX_CODE_LEN + 1) > (IDX_W + 1)) ? (MAX_CODE_LEN + 1) : (IDX_W + 1);
	localparam int VAL_W  = (NODE_W > CODE_W) ? NODE_W : CODE_W;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_DECODE = 1'b1
	} ptd_cmd_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [SYM_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ptd_ram_req_t;

endpackage

@@ rtl/ptd_item_if.sv @@
// ----------------------------------------------------------------------------
// ptd_item_if
// Request channel of the decoder: table loads and code bits.
// ----------------------------------------------------------------------------
interface ptd_item_if;
	import ptd_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [SYM_W-1:0]  symbol_in;
	logic [CODE_W-1:0] code_value;
	logic [LEN_W-1:0]  code_length;
	logic              code_bit;

	modport source (
		output valid, command, symbol_in, code_value, code_length, code_bit,
		input  ready
	);

	modport sink (
		input  valid, command, symbol_in, code_value, code_length, code_bit,
		output ready
	);
endinterface

@@ rtl/ptd_result_if.sv @@
// ----------------------------------------------------------------------------
// ptd_result_if
// Result channel of the decoder: decoded symbols and walk errors.
// ----------------------------------------------------------------------------
interface ptd_result_if;
	import ptd_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol_out;
	logic             error;

	modport source (
		output valid, symbol_out, error,
		input  ready
	);

	modport sink (
		input  valid, symbol_out, error,
		output ready
	);
endinterface

@@ rtl/ptd_node_ram.sv @@
// ----------------------------------------------------------------------------
// ptd_node_ram
// Node table storage: one write and one registered read port, with a
// clearing sweep after reset that zeroes every node, one per cycle.
// ----------------------------------------------------------------------------
module ptd_node_ram
	import ptd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ptd_ram_req_t     req,
	output logic [SYM_W-1:0] rd_data,
	output logic             clearing
);

	logic [SYM_W-1:0] mem [TABLE_DEPTH];
	logic [IDX_W-1:0] clr_addr_q;
	logic             clr_busy_q;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [SYM_W-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = req.we;
			wr_addr = req.waddr;
			wr_data = req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

	assign clearing = clr_busy_q;

endmodule

@@ rtl/prefix_code_tree_decoder.sv @@
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder
// Decodes a prefix code one bit per request by walking a heap-indexed
// binary tree held in a node table; load requests fill the table.
// ----------------------------------------------------------------------------
//  channel  modport  payload                                          role
//  item     sink     command, symbol_in, code_value, code_length,     load / code bit
//                    code_bit
//  result   source   symbol_out, error                                decoded symbol
//
//  A load writes the table when it is taken; a decode reads its node through
//  the synchronous table port into its stage, then takes the tree step into the
//  result register. After reset all TABLE_DEPTH (16384) nodes are zeroed;
//  item.ready stays low for that sweep. A stalled result holds its register;
//  a decode waits in its stage for the slot, and item.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder
	import ptd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ptd_item_if.sink     item,
	ptd_result_if.source result
);

	ptd_ram_req_t     ram_req;
	logic [SYM_W-1:0] rd_data;
	logic             clearing;

	logic [IDX_W-1:0] walk_q;
	logic             valid_s1;
	logic             err_s1;
	logic [IDX_W-1:0] next_s1;

	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_err_q;

	logic             accept;
	logic             is_decode;
	logic [IDX_W+1:0] dec_next;
	logic             dec_err;
	logic [VAL_W-1:0] load_mask;
	logic [VAL_W-1:0] load_node;
	logic             load_ok;
	logic             retire;
	logic             emit;

	ptd_node_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ram_req),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	assign item.ready = !clearing && !valid_s1;
	assign accept     = item.valid && item.ready;
	assign is_decode  = (item.command == CMD_DECODE);

	assign dec_next  = {1'b0, walk_q, 1'b0} + (IDX_W + 2)'(1) + (IDX_W + 2)'(item.code_bit);
	assign dec_err   = (dec_next >= (IDX_W + 2)'(TABLE_DEPTH));
	assign load_mask = (VAL_W'(1) << item.code_length) - VAL_W'(1);
	assign load_node = load_mask + (VAL_W'(item.code_value) & load_mask);
	assign load_ok   = (item.code_length != '0) && (int'(item.code_length) <= MAX_CODE_LEN)
		&& (load_node < VAL_W'(TABLE_DEPTH));

	always_comb begin
		ram_req.we    = accept && !is_decode && load_ok;
		ram_req.waddr = load_node[IDX_W-1:0];
		ram_req.wdata = item.symbol_in;
		ram_req.re    = accept && is_decode && !dec_err;
		ram_req.raddr = dec_next[IDX_W-1:0];
	end

	assign retire = valid_s1 && (!out_valid_q || result.ready);
	assign emit   = err_s1 || (rd_data != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && is_decode) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_decode) begin
			err_s1  <= dec_err;
			next_s1 <= dec_next[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (retire) begin
			walk_q <= emit ? '0 : next_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && emit) begin
			out_sym_q <= err_s1 ? '0 : rd_data;
			out_err_q <= err_s1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.symbol_out = out_sym_q;
	assign result.error      = out_err_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("request taken during table clear");

	a_walk_root_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && emit) |=> (walk_q == '0))
		else $error("walk not at root after a result");

	a_error_zero_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.error) |-> (result.symbol_out == '0))
		else $error("error result carries a symbol");

	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !retire) |=> (valid_s1 && $stable(next_s1) && $stable(rd_data)))
		else $error("stalled decode lost its node data");

endmodule

@@ verif/ptd_checker.sv @@
// ----------------------------------------------------------------------------
// ptd_checker
// Watches the request and result channels of the prefix code tree decoder,
// keeps its own node table and walk position, predicts every decoded symbol
// and walk error, and compares each result in order against that prediction.
// ----------------------------------------------------------------------------
module ptd_checker
	import ptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ptd_item_if         item,
	ptd_result_if       result,
	output int unsigned fail_count,
	output int unsigned pending_count,
	output int unsigned symbol_count,
	output int unsigned error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		logic             error;
	} decoded_sym_t;

	logic [SYM_W-1:0] tree_nodes [TABLE_DEPTH];
	int unsigned      walk_node;
	decoded_sym_t     decoded_q [$];
	decoded_sym_t     oldest_decode;

	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic walk_tree(input ptd_cmd_t cmd, input logic [SYM_W-1:0] sym,
	                         input logic [CODE_W-1:0] cval, input logic [LEN_W-1:0] clen,
	                         input logic cbit);
		int unsigned node;
		int unsigned next;
		if (cmd == CMD_LOAD) begin
			if (clen != 0 && clen <= MAX_CODE_LEN) begin
				node = (32'd1 << clen) - 1 + (cval & ((32'd1 << clen) - 1));
				if (node < TABLE_DEPTH)
					tree_nodes[node] = sym;
			end
		end else begin
			next = 2 * walk_node + 1 + cbit;
			if (next >= TABLE_DEPTH) begin
				walk_node = 0;
				decoded_q.push_back('{symbol_out: '0, error: 1'b1});
			end else if (tree_nodes[next] != 0) begin
				decoded_q.push_back('{symbol_out: tree_nodes[next], error: 1'b0});
				walk_node = 0;
			end else begin
				walk_node = next;
			end
		end
	endtask

	initial begin
		foreach (tree_nodes[i])
			tree_nodes[i] = '0;
		walk_node     = 0;
		fail_count    = 0;
		pending_count = 0;
		symbol_count  = 0;
		error_count   = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("result with nothing pending",
					                {result.error, result.symbol_out}, 0);
				end else begin
					oldest_decode = decoded_q.pop_front();
					if (result.symbol_out !== oldest_decode.symbol_out)
						report_mismatch("symbol_out", result.symbol_out, oldest_decode.symbol_out);
					if (result.error !== oldest_decode.error)
						report_mismatch("error", result.error, oldest_decode.error);
					if (oldest_decode.error)
						error_count++;
					else
						symbol_count++;
				end
			end
			if (item.valid && item.ready)
				walk_tree(ptd_cmd_t'(item.command), item.symbol_in, item.code_value,
				          item.code_length, item.code_bit);
			pending_count = decoded_q.size();
		end
	end

endmodule

@@ verif/tb_prefix_code_tree_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_prefix_code_tree_decoder
// Drives the decoder with table loads and code bit streams: a short directed
// opening, then random prefix code trees loaded and decoded with noise, under
// bursty requests, a stalling result receiver, one long stall and drain
// pauses. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_prefix_code_tree_decoder
	import ptd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 800;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int LONG_STALL     = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_LEAVES     = 32;

	logic clk = 1'b0;
	logic arst_n;

	ptd_item_if   item ();
	ptd_result_if result ();

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned symbol_count;
	int unsigned error_count;

	prefix_code_tree_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	ptd_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.symbol_count  (symbol_count),
		.error_count   (error_count)
	);

	always #5 clk = ~clk;

	logic        long_stall_go   = 1'b0;
	logic        long_stall_done = 1'b0;
	int unsigned burst_left      = 0;
	int unsigned request_count   = 0;
	int unsigned load_count      = 0;
	int unsigned decode_count    = 0;
	int unsigned counted_items   = 0;
	int unsigned tree_count      = 0;
	int unsigned idle_cycles     = 0;

	int unsigned leaf_len   [MAX_LEAVES];
	int unsigned leaf_code  [MAX_LEAVES];
	int unsigned inner_len  [MAX_LEAVES];
	int unsigned inner_code [MAX_LEAVES];
	int unsigned n_leaves;
	int unsigned n_inner;

	task automatic send_item(input ptd_cmd_t cmd, input logic [SYM_W-1:0] sym,
	                         input logic [CODE_W-1:0] cval, input logic [LEN_W-1:0] clen,
	                         input logic cbit);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item.valid       = 1'b1;
		item.command     = cmd;
		item.symbol_in   = sym;
		item.code_value  = cval;
		item.code_length = clen;
		item.code_bit    = cbit;
		do
			@(posedge clk);
		while (!item.ready);
		@(negedge clk);
		request_count++;
		if (cmd == CMD_LOAD) begin
			load_count++;
			if (clen != 0 && clen <= MAX_CODE_LEN)
				counted_items++;
		end else begin
			decode_count++;
			counted_items++;
		end
	endtask

	task automatic send_load(input logic [SYM_W-1:0] sym, input int unsigned code,
	                         input int unsigned clen);
		int unsigned mask;
		int unsigned cval;
		mask = (32'd1 << clen) - 1;
		cval = ($urandom_range(0, 8191) & ~mask) | (code & mask);
		send_item(CMD_LOAD, sym, cval[CODE_W-1:0], clen[LEN_W-1:0],
		          1'($urandom_range(0, 1)));
	endtask

	task automatic send_bit(input logic cbit);
		send_item(CMD_DECODE, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom), cbit);
	endtask

	task automatic build_code_tree(input int unsigned target, input int unsigned max_len,
	                               input logic chain);
		int unsigned pick;
		int unsigned tries;
		n_leaves     = 1;
		leaf_len[0]  = 0;
		leaf_code[0] = 0;
		n_inner      = 0;
		tries        = 0;
		while (n_leaves < target && tries < 200) begin
			tries++;
			if (chain && $urandom_range(0, 9) < 8)
				pick = n_leaves - 1;
			else
				pick = $urandom_range(0, n_leaves - 1);
			if (leaf_len[pick] < max_len) begin
				inner_len[n_inner]   = leaf_len[pick];
				inner_code[n_inner]  = leaf_code[pick];
				n_inner++;
				leaf_len[pick]       = leaf_len[pick] + 1;
				leaf_code[pick]      = leaf_code[pick] << 1;
				leaf_len[n_leaves]   = leaf_len[pick];
				leaf_code[n_leaves]  = leaf_code[pick] | 1;
				n_leaves++;
			end
		end
	endtask

	// receiver: stall on its own pattern, plus one long hold-off on request
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned tick;
		result.ready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(1, 60);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (long_stall_go && !long_stall_done) begin
					result.ready = 1'b0;
					repeat (LONG_STALL) @(negedge clk);
					long_stall_done = 1'b1;
				end
				case (mode)
					0: result.ready = 1'b1;
					1: result.ready = 1'($urandom_range(0, 1));
					2: result.ready = ($urandom_range(0, 3) != 0);
					3: result.ready = ($urandom_range(0, 4) == 0);
					default: result.ready = (tick % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
			$display("prefix_code_tree_decoder test failed");
			$finish;
		end
	end

	initial begin
		int unsigned base;
		int unsigned phase;
		int unsigned n_syms;
		int unsigned k;
		arst_n           = 1'b0;
		item.valid       = 1'b0;
		item.command     = CMD_LOAD;
		item.symbol_in   = '0;
		item.code_value  = '0;
		item.code_length = '0;
		item.code_bit    = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// lengths out of range, wide codeword, extremes of symbol and length
		send_item(CMD_LOAD, 8'h11, 13'h0000, 4'd0, 1'b0);
		send_item(CMD_LOAD, 8'h22, 13'h1FFF, 4'd15, 1'b1);
		send_item(CMD_LOAD, 8'hFF, 13'h0001, 4'd1, 1'b0);
		send_item(CMD_LOAD, 8'h01, 13'h1FFD, 4'd2, 1'b1);
		send_item(CMD_LOAD, 8'h80, 13'h0000, 4'd13, 1'b0);
		send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);
		// empty the right child, then walk the all-ones path off the table
		send_item(CMD_LOAD, 8'h00, 13'h0001, 4'd1, 1'b1);
		repeat (14) send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);

		base  = counted_items;
		phase = 0;
		while (counted_items - base < RANDOM_ITEMS) begin
			if (phase == 1 || $urandom_range(0, 3) == 0) begin
				item.valid = 1'b0;
				wait (pending_count == 0);
				@(negedge clk);
			end
			if (phase % 6 == 5)
				build_code_tree($urandom_range(8, 14), MAX_CODE_LEN, 1'b1);
			else
				build_code_tree($urandom_range(2, 16), $urandom_range(1, 6), 1'b0);
			tree_count++;
			for (int i = 0; i < n_inner; i++)
				if (inner_len[i] != 0)
					send_load(8'h00, inner_code[i], inner_len[i]);
			for (int i = 0; i < n_leaves; i++)
				send_load(SYM_W'($urandom_range(1, 255)), leaf_code[i], leaf_len[i]);
			if (phase == 3)
				long_stall_go = 1'b1;
			n_syms = $urandom_range(20, 60);
			repeat (n_syms) begin
				if ($urandom_range(0, 19) == 0)
					send_bit(1'($urandom_range(0, 1)));
				if ($urandom_range(0, 24) == 0)
					send_item(CMD_LOAD, SYM_W'($urandom), CODE_W'($urandom),
					          LEN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
				k = $urandom_range(0, n_leaves - 1);
				for (int b = leaf_len[k] - 1; b >= 0; b--)
					send_bit(1'((leaf_code[k] >> b) & 1));
			end
			phase++;
		end

		item.valid = 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d requests (%0d table loads, %0d code bits) over %0d code trees",
		         request_count, load_count, decode_count, tree_count);
		$display("checked %0d decoded symbols and %0d walk errors", symbol_count, error_count);
		if (fail_count == 0) begin
			$display("prefix_code_tree_decoder test passed");
		end else begin
			$display("prefix_code_tree_decoder test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ptd_pkg.sv
rtl/ptd_item_if.sv
rtl/ptd_result_if.sv
rtl/ptd_node_ram.sv
rtl/prefix_code_tree_decoder.sv
verif/ptd_checker.sv
verif/tb_prefix_code_tree_decoder.sv
